### rtl/pcg32_random_range_generator_assert.svh
// Assertion macros shared by the PCG32 range generator RTL.
`ifndef PCG32_RANDOM_RANGE_GENERATOR_ASSERT_SVH
`define PCG32_RANDOM_RANGE_GENERATOR_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define PCG_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pcg32 assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define PCG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pcg32 assertion failed");
`else
`define PCG_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define PCG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/pcg32rr_pkg.sv
// Package: types, request codes and generator constants for the PCG32 range generator.
`default_nettype none
package pcg32rr_pkg;

    localparam logic [63:0] LCG_MULT   = 64'd6364136223846793005;
    localparam logic [63:0] LCG_INC    = 64'hda3e39cb94b95bdb;
    localparam logic [63:0] SEED_VALUE = 64'h853c49e6748fea9b;

    // Request kinds; codes 6 and 7 behave as raw 32-bit draws.
    localparam logic [2:0] KIND_RAW32  = 3'd0;
    localparam logic [2:0] KIND_URNG32 = 3'd1;
    localparam logic [2:0] KIND_RAW64  = 3'd2;
    localparam logic [2:0] KIND_URNG64 = 3'd3;
    localparam logic [2:0] KIND_SRNG32 = 3'd4;
    localparam logic [2:0] KIND_SRNG64 = 3'd5;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] range_low;
        logic [63:0] range_high;
    } req_t;

    typedef struct packed {
        logic [63:0] value;
        logic        empty_range;
    } rsp_t;

endpackage
`default_nettype wire

### rtl/pcg32_random_range_generator.sv
// Top level: PCG32 XSH-RR generator with raw and ranged draws on a shared multiplier and divider.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | input     | in_valid / in_ready | pcg32rr_pkg::req_t (kind, bounds)
//  out     | output    | out_valid/out_ready | pcg32rr_pkg::rsp_t (value, flag)
//
// Each 32-bit draw runs on one 32x32 multiplier (three partial products of
// the 64-bit LCG step, then the increment add). A ranged draw then runs a
// restoring remainder loop, one quotient bit per cycle, over 32 dividend bits
// for 32-bit kinds and 64 for 64-bit kinds. Ranged kinds with distinct bounds
// take the remainder loop after the draws; other kinds go straight to the
// output step. in_ready is high only in idle; a finished result waits in the
// output register, so the next beat can be taken while out_ready is low.
// Reset loads the seed into the generator state and empties the output stage.
`default_nettype none
`include "pcg32_random_range_generator_assert.svh"
module pcg32_random_range_generator
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pcg32rr_pkg::req_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pcg32rr_pkg::rsp_t       out_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL0 = 4'd1;
    localparam logic [3:0] ST_MUL1 = 4'd2;
    localparam logic [3:0] ST_MUL2 = 4'd3;
    localparam logic [3:0] ST_MUL3 = 4'd4;
    localparam logic [3:0] ST_PREP = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_FIN  = 4'd7;

    logic [3:0]  state_reg, state_next;
    logic [2:0]  kind_reg, kind_next;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] hi_reg, hi_next;
    logic [63:0] gen_reg, gen_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] r_reg, r_next;
    logic        second_reg, second_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [63:0] div_reg, div_next;
    logic [63:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        empty_reg, empty_next;
    logic        out_valid_reg, out_valid_next;
    pcg32rr_pkg::rsp_t out_data_reg, out_data_next;

    logic        is_wide, is_ranged, is_signed;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [31:0] xs;
    logic [4:0]  rot;
    logic [63:0] rot_wide;
    logic [31:0] word;
    logic [63:0] lo_w, hi_w, span, dist_w, r_mag, d_mag;
    logic [64:0] rem_sh, rem_diff;
    logic [63:0] fin_sum;
    logic        in_acc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Kind decode; unused codes fall through as raw 32-bit.
    always_comb
    begin
        is_wide   = (kind_reg == pcg32rr_pkg::KIND_RAW64) ||
                    (kind_reg == pcg32rr_pkg::KIND_URNG64) ||
                    (kind_reg == pcg32rr_pkg::KIND_SRNG64);
        is_ranged = (kind_reg == pcg32rr_pkg::KIND_URNG32) ||
                    (kind_reg == pcg32rr_pkg::KIND_URNG64) ||
                    (kind_reg == pcg32rr_pkg::KIND_SRNG32) ||
                    (kind_reg == pcg32rr_pkg::KIND_SRNG64);
        is_signed = (kind_reg == pcg32rr_pkg::KIND_SRNG32) ||
                    (kind_reg == pcg32rr_pkg::KIND_SRNG64);
    end

    // Shared 32x32 multiplier: low 64 bits of state * LCG_MULT as
    // sL*mL + ((sL*mH + sH*mL) << 32).
    assign mul_a = (state_reg == ST_MUL2) ? gen_reg[63:32] : gen_reg[31:0];
    assign mul_b = (state_reg == ST_MUL1) ? pcg32rr_pkg::LCG_MULT[63:32]
                                          : pcg32rr_pkg::LCG_MULT[31:0];
    assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

    // XSH-RR output word from the current (old) state.
    assign xs       = 32'(((gen_reg >> 18) ^ gen_reg) >> 27);
    assign rot      = gen_reg[63:59];
    assign rot_wide = {xs, xs} >> rot;
    assign word     = rot_wide[31:0];

    // Operand preparation at the request's width.
    always_comb
    begin
        lo_w   = is_wide ? lo_reg : {32'd0, lo_reg[31:0]};
        hi_w   = is_wide ? hi_reg : {32'd0, hi_reg[31:0]};
        span   = hi_w - lo_w;
        dist_w = is_wide ? span : {32'd0, span[31:0]};
        r_mag  = r_reg;
        d_mag  = dist_w;
        if (is_signed)
        begin
            if (is_wide)
            begin
                if (r_reg[63])
                    r_mag = -r_reg;
                if (dist_w[63])
                    d_mag = -dist_w;
            end
            else
            begin
                if (r_reg[31])
                    r_mag = {32'd0, -r_reg[31:0]};
                if (dist_w[31])
                    d_mag = {32'd0, -dist_w[31:0]};
            end
        end
    end

    // One restoring step of the remainder loop.
    assign rem_sh   = {rem_reg, dvd_reg[63]};
    assign rem_diff = rem_sh - {1'b0, div_reg};
    assign fin_sum  = lo_reg + rem_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        gen_next       = gen_reg;
        acc_next       = acc_reg;
        r_next         = r_reg;
        second_next    = second_reg;
        dvd_next       = dvd_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // Drop the result once the sink takes it.
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    kind_next   = in_data.kind;
                    lo_next     = in_data.range_low;
                    hi_next     = in_data.range_high;
                    r_next      = '0;
                    second_next = (in_data.kind == pcg32rr_pkg::KIND_RAW64) ||
                                  (in_data.kind == pcg32rr_pkg::KIND_URNG64) ||
                                  (in_data.kind == pcg32rr_pkg::KIND_SRNG64);
                    state_next  = ST_MUL0;
                end
            end
            ST_MUL0:
            begin
                // First word drawn lands in the high half for 64-bit kinds.
                r_next     = {r_reg[31:0], word};
                acc_next   = prod;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                acc_next   = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                acc_next   = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                gen_next = acc_reg + pcg32rr_pkg::LCG_INC;
                if (second_reg)
                begin
                    second_next = 1'b0;
                    state_next  = ST_MUL0;
                end
                else
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                // lo_reg becomes the addend of the final sum.
                priority if (!is_ranged)
                begin
                    empty_next = 1'b0;
                    lo_next    = '0;
                    rem_next   = r_reg;
                    state_next = ST_FIN;
                end
                else if (lo_w == hi_w)
                begin
                    empty_next = 1'b1;
                    lo_next    = lo_w;
                    rem_next   = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    empty_next = 1'b0;
                    lo_next    = lo_w;
                    rem_next   = '0;
                    div_next   = d_mag;
                    dvd_next   = is_wide ? r_mag : {r_mag[31:0], 32'd0};
                    cnt_next   = is_wide ? 7'd64 : 7'd32;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!rem_diff[64])
                    rem_next = rem_diff[63:0];
                else
                    rem_next = rem_sh[63:0];
                dvd_next = {dvd_reg[62:0], 1'b0};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.value       = is_wide ? fin_sum
                                                        : {32'd0, fin_sum[31:0]};
                    out_data_next.empty_range = empty_reg;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_reg       <= pcg32rr_pkg::SEED_VALUE;
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        acc_reg      <= acc_next;
        r_reg        <= r_next;
        dvd_reg      <= dvd_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        empty_reg    <= empty_next;
        out_data_reg <= out_data_next;
    end

    `PCG_ASSERT_NEXT(a_accept_starts_draw, clk, rst_n, in_acc, state_reg == ST_MUL0)
    `PCG_ASSERT_NEXT(a_state_only_in_step, clk, rst_n, state_reg != ST_MUL3, $stable(gen_reg))
    `PCG_ASSERT_NOW(a_divisor_nonzero, clk, rst_n, state_reg == ST_DIV, div_reg != 64'd0)
    `PCG_ASSERT_NOW(a_rem_below_div, clk, rst_n, state_reg == ST_DIV, rem_reg < div_reg)

endmodule
`default_nettype wire
